[hdl/nnsa_pkg.sv]
// ----------------------------------------------------------------------------
// nnsa_pkg
// Types, constants and helpers for the nearest-neighbor scale address unit.
// ----------------------------------------------------------------------------
package nnsa_pkg;

  localparam int unsigned MaxDim   = 8192;
  localparam int unsigned RegW     = 14;
  localparam int unsigned CoordW   = 13;
  localparam int unsigned ProdW    = 26;
  localparam int unsigned DivSteps = CoordW;
  localparam int unsigned NumStg   = DivSteps + 1;

  localparam logic [2:0] RegSrcW   = 3'd0;
  localparam logic [2:0] RegSrcH   = 3'd1;
  localparam logic [2:0] RegPlaceX = 3'd2;
  localparam logic [2:0] RegPlaceY = 3'd3;
  localparam logic [2:0] RegRectW  = 3'd4;
  localparam logic [2:0] RegRectH  = 3'd5;
  localparam logic [2:0] RegCanvW  = 3'd6;
  localparam logic [2:0] RegCanvH  = 3'd7;

  // One axis of the restoring divider: partial remainder, unused dividend
  // bits (MSB first) and quotient bits collected so far.
  typedef struct packed {
    logic [RegW-1:0]   rem;
    logic [CoordW-1:0] num;
    logic [CoordW-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic              ok;
    div_lane_t         lx;
    div_lane_t         ly;
  } stage_t;

  function automatic logic [RegW-1:0] clamp_size(input logic [RegW-1:0] v);
    clamp_size = (v > RegW'(MaxDim)) ? RegW'(MaxDim) : v;
  endfunction

  // One quotient bit: shift in the next dividend bit, subtract if it fits.
  function automatic div_lane_t div_step(input div_lane_t l, input logic [RegW-1:0] d);
    logic [RegW:0] t;
    logic          ge;
    div_lane_t     o;
    t  = {l.rem, l.num[CoordW-1]};
    ge = (t >= {1'b0, d});
    o.rem = ge ? RegW'(t - {1'b0, d}) : t[RegW-1:0];
    o.num = {l.num[CoordW-2:0], 1'b0};
    o.quo = {l.quo[CoordW-2:0], ge};
    return o;
  endfunction

endpackage

[hdl/nearest_neighbor_scale_address_unit.sv]
// ----------------------------------------------------------------------------
// nearest_neighbor_scale_address_unit
// Canvas and source pixel addresses for nearest-neighbor image scaling.
// ----------------------------------------------------------------------------
// One item per clock when the output side takes one per clock. The entry stage,
// loaded at the accepting edge, forms the products offset * source size, the
// canvas position and the write checks, then a 13-stage restoring divider (one
// quotient bit per stage, both axes in parallel) divides by the rectangle size.
// The pipeline advances as a whole whenever the output register is empty or
// being taken, so s_axis_tready falls only while a result waits. Configuration
// is taken at any time (cfg_ready_o is always high) but must only change while
// the unit is empty. Sizes above 8192 act as 8192. write_enable is 0, and all
// addresses 0, when a size is zero, the offset lies outside the rectangle or the
// canvas position lies off the canvas.
module nearest_neighbor_scale_address_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [13:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // rect_row[12:0], rect_column[25:13], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata   // canvas_x, canvas_y, sample_x, sample_y,
                                     // write_enable[52], zero pad
);

  localparam int unsigned Last = nnsa_pkg::NumStg - 1;
  localparam int unsigned RW   = nnsa_pkg::RegW;
  localparam int unsigned CW   = nnsa_pkg::CoordW;

  logic [RW-1:0] src_w_q, src_h_q, place_x_q, place_y_q;
  logic [RW-1:0] rect_w_q, rect_h_q, canv_w_q, canv_h_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q   <= '0;
      src_h_q   <= '0;
      place_x_q <= '0;
      place_y_q <= '0;
      rect_w_q  <= '0;
      rect_h_q  <= '0;
      canv_w_q  <= '0;
      canv_h_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        nnsa_pkg::RegSrcW:   src_w_q   <= cfg_data_i;
        nnsa_pkg::RegSrcH:   src_h_q   <= cfg_data_i;
        nnsa_pkg::RegPlaceX: place_x_q <= cfg_data_i;
        nnsa_pkg::RegPlaceY: place_y_q <= cfg_data_i;
        nnsa_pkg::RegRectW:  rect_w_q  <= cfg_data_i;
        nnsa_pkg::RegRectH:  rect_h_q  <= cfg_data_i;
        nnsa_pkg::RegCanvW:  canv_w_q  <= cfg_data_i;
        nnsa_pkg::RegCanvH:  canv_h_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamped sizes.
  logic [RW-1:0] sw, sh, rw, rh, cw, ch;
  assign sw = nnsa_pkg::clamp_size(src_w_q);
  assign sh = nnsa_pkg::clamp_size(src_h_q);
  assign rw = nnsa_pkg::clamp_size(rect_w_q);
  assign rh = nnsa_pkg::clamp_size(rect_h_q);
  assign cw = nnsa_pkg::clamp_size(canv_w_q);
  assign ch = nnsa_pkg::clamp_size(canv_h_q);

  logic adv;
  logic vld_q [nnsa_pkg::NumStg];
  nnsa_pkg::stage_t stg_q [nnsa_pkg::NumStg];
  nnsa_pkg::stage_t stg_d [nnsa_pkg::NumStg];

  assign adv           = !vld_q[Last] || m_axis_tready;
  assign s_axis_tready = adv;

  // Entry stage: products, canvas position, write checks.
  logic [CW-1:0]              row, col;
  logic signed [RW:0]         xs, ys;
  logic [nnsa_pkg::ProdW-1:0] px, py;
  logic                       ok_in;

  assign row = s_axis_tdata[12:0];
  assign col = s_axis_tdata[25:13];

  always_comb begin
    xs = $signed({place_x_q[RW-1], place_x_q}) + $signed({2'b00, col});
    ys = $signed({place_y_q[RW-1], place_y_q}) + $signed({2'b00, row});
    px = nnsa_pkg::ProdW'(col) * nnsa_pkg::ProdW'(sw);
    py = nnsa_pkg::ProdW'(row) * nnsa_pkg::ProdW'(sh);
    ok_in = (sw != '0) && (sh != '0) && (rw != '0) && (rh != '0) &&
            ({1'b0, row} < rh) && ({1'b0, col} < rw) &&
            !xs[RW] && (xs[RW-1:0] < cw) &&
            !ys[RW] && (ys[RW-1:0] < ch);

    stg_d[0].cx     = xs[CW-1:0];
    stg_d[0].cy     = ys[CW-1:0];
    stg_d[0].ok     = ok_in;
    stg_d[0].lx.rem = {1'b0, px[nnsa_pkg::ProdW-1:CW]};
    stg_d[0].lx.num = px[CW-1:0];
    stg_d[0].lx.quo = '0;
    stg_d[0].ly.rem = {1'b0, py[nnsa_pkg::ProdW-1:CW]};
    stg_d[0].ly.num = py[CW-1:0];
    stg_d[0].ly.quo = '0;

    // Divider stages, one quotient bit each.
    for (int k = 1; k < nnsa_pkg::NumStg; k++) begin
      stg_d[k]    = stg_q[k-1];
      stg_d[k].lx = nnsa_pkg::div_step(stg_q[k-1].lx, rw);
      stg_d[k].ly = nnsa_pkg::div_step(stg_q[k-1].ly, rh);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < nnsa_pkg::NumStg; k++) vld_q[k] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= s_axis_tvalid;
      for (int k = 1; k < nnsa_pkg::NumStg; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < nnsa_pkg::NumStg; k++) stg_q[k] <= stg_d[k];
    end
  end

  // Quotient < source size whenever the offset is inside the rectangle,
  // so no clamp is needed on written items.
  logic we;
  assign we            = stg_q[Last].ok;
  assign m_axis_tvalid = vld_q[Last];
  assign m_axis_tdata  = we ? {3'b000, 1'b1, stg_q[Last].ly.quo, stg_q[Last].lx.quo,
                                stg_q[Last].cy, stg_q[Last].cx}
                            : '0;

  a_last_fed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(vld_q[Last]) |-> $past(vld_q[Last-1]))
    else $error("output valid without item in last divider stage");

  a_entry_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[0] && adv) |=> vld_q[1])
    else $error("item lost between entry and divider");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && !s_axis_tready) |-> m_axis_tvalid)
    else $error("input stalled while output empty");

endmodule

[tb/nearest_neighbor_scale_address_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_scale_address_unit_tb
// Self-checking bench for the scale address unit: directed corner items and
// random rows/columns over several register settings, checked against an
// in-bench address predictor, with random idle cycles on both stream sides.
// ----------------------------------------------------------------------------
module nearest_neighbor_scale_address_unit_tb;

  // row in the low bits, as on s_axis_tdata
  typedef struct packed {
    logic [12:0] col;
    logic [12:0] row;
  } pixel_req_t;

  typedef struct packed {
    logic [12:0] cx;
    logic [12:0] cy;
    logic [12:0] sx;
    logic [12:0] sy;
    logic        we;
  } pixel_addr_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [13:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // rect_row[12:0], rect_column[25:13]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // canvas_x, canvas_y, sample_x, sample_y, we

  nearest_neighbor_scale_address_unit dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Register shadow used by the predictor
  logic [13:0] regs [8];

  pixel_req_t  pending_reqs [$];
  pixel_addr_t expected_addrs [$];
  int          mismatches = 0;
  int unsigned cycles = 0;
  bit          rx_hold = 1'b0;   // long receiver stall
  bit          tx_pause = 1'b0;  // sender drains before going on
  bit          tx_took = 1'b0;   // offered item taken at the last rising edge

  function automatic logic [13:0] dim(input logic [13:0] v);
    return (v > 14'd8192) ? 14'd8192 : v;
  endfunction

  function automatic logic [12:0] nearest(input int unsigned off, input int unsigned src,
                                          input int unsigned dst);
    int unsigned q;
    q = (off * src) / dst;
    return (q > src - 1) ? 13'(src - 1) : 13'(q);
  endfunction

  function automatic pixel_addr_t predict_addr(input pixel_req_t r);
    pixel_addr_t a;
    int sw, sh, rw, rh, cw, ch, x, y;
    bit ok;
    sw = int'(dim(regs[nnsa_pkg::RegSrcW]));   sh = int'(dim(regs[nnsa_pkg::RegSrcH]));
    rw = int'(dim(regs[nnsa_pkg::RegRectW]));  rh = int'(dim(regs[nnsa_pkg::RegRectH]));
    cw = int'(dim(regs[nnsa_pkg::RegCanvW]));  ch = int'(dim(regs[nnsa_pkg::RegCanvH]));
    x = $signed(regs[nnsa_pkg::RegPlaceX]) + int'(r.col);
    y = $signed(regs[nnsa_pkg::RegPlaceY]) + int'(r.row);
    ok = sw != 0 && sh != 0 && rw != 0 && rh != 0 && int'(r.row) < rh && int'(r.col) < rw
         && x >= 0 && x < cw && y >= 0 && y < ch;
    a = '0;
    if (ok) begin
      a.cx = 13'(x);
      a.cy = 13'(y);
      a.sx = nearest(int'(r.col), sw, rw);
      a.sy = nearest(int'(r.row), sh, rh);
      a.we = 1'b1;
    end
    return a;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // Input side bookkeeping at the accepting edge
  int tx_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      expected_addrs.insert(expected_addrs.size(),
                            predict_addr(pixel_req_t'(s_axis_tdata[25:0])));
      void'(pending_reqs.pop_front());
      tx_gap = $urandom_range(0, 3);
      tx_took = 1'b1;
    end
  end

  // Driver: one item at a time from the queue, random gap before each
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && !tx_took) begin
        // item still waiting: hold it
      end else begin
        tx_took = 1'b0;
        if (pending_reqs.size() != 0 && tx_gap == 0 && !tx_pause) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {6'd0, pending_reqs[0]};
        end else begin
          s_axis_tvalid <= 1'b0;
          if (tx_gap > 0) tx_gap--;
        end
      end
    end
  end

  // Monitor: check at the rising edge, choose ready at the falling edge
  int rx_gap = 0;
  always @(posedge clk_i) begin
    pixel_addr_t got, want;
    cycles++;
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[12:0], m_axis_tdata[25:13], m_axis_tdata[38:26],
             m_axis_tdata[51:39], m_axis_tdata[52]};
      if (expected_addrs.size() == 0) begin
        report_mismatch("unexpected item", 0, 0);
      end else begin
        want = expected_addrs.pop_front();
        if (got.cx != want.cx) report_mismatch("canvas_x", int'(got.cx), int'(want.cx));
        if (got.cy != want.cy) report_mismatch("canvas_y", int'(got.cy), int'(want.cy));
        if (got.sx != want.sx) report_mismatch("sample_x", int'(got.sx), int'(want.sx));
        if (got.sy != want.sy) report_mismatch("sample_y", int'(got.sy), int'(want.sy));
        if (got.we != want.we)
          report_mismatch("write_enable", int'(got.we), int'(want.we));
      end
      rx_gap = $urandom_range(0, 3);
    end
    if (m_axis_tdata[55:53] != 3'd0)
      report_mismatch("pad bits", int'(m_axis_tdata[55:53]), 0);
  end

  always @(negedge clk_i) begin
    if (rx_hold || !rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      m_axis_tready <= 1'b0;
      rx_gap--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (cycles > 400000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [13:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    regs[idx] = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Idle point: everything queued is sent and every result is back
  task automatic drain();
    while (pending_reqs.size() != 0 || expected_addrs.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [13:0] sw, sh, px, py, rw, rh, cw, ch);
    write_reg(nnsa_pkg::RegSrcW, sw);   write_reg(nnsa_pkg::RegSrcH, sh);
    write_reg(nnsa_pkg::RegPlaceX, px); write_reg(nnsa_pkg::RegPlaceY, py);
    write_reg(nnsa_pkg::RegRectW, rw);  write_reg(nnsa_pkg::RegRectH, rh);
    write_reg(nnsa_pkg::RegCanvW, cw);  write_reg(nnsa_pkg::RegCanvH, ch);
  endtask

  task automatic push_req(input int r, input int c);
    pending_reqs.insert(pending_reqs.size(), '{row: 13'(r), col: 13'(c)});
  endtask

  // Mostly offsets inside the rectangle, some anywhere
  task automatic random_phase(input int n);
    int rw, rh;
    rw = int'(dim(regs[nnsa_pkg::RegRectW]));
    rh = int'(dim(regs[nnsa_pkg::RegRectH]));
    repeat (n) begin
      if ($urandom_range(0, 9) < 8 && rw > 0 && rh > 0)
        push_req($urandom_range(0, rh - 1), $urandom_range(0, rw - 1));
      else
        push_req($urandom_range(0, 8191), $urandom_range(0, 8191));
    end
  endtask

  function automatic logic [13:0] rnd_size();
    case ($urandom_range(0, 5))
      0: return 14'($urandom_range(1, 16));
      1: return 14'($urandom_range(8192, 16383));
      default: return 14'($urandom_range(1, 8192));
    endcase
  endfunction

  initial begin
    foreach (regs[i]) regs[i] = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // reset values: every size zero, so no writes
    push_req(0, 0);
    push_req(8191, 8191);
    drain();

    // upscale, partly off canvas at the low edge
    set_regs(14'd7, 14'd5, -14'sd3, -14'sd2, 14'd20, 14'd13, 14'd100, 14'd50);
    push_req(0, 0); push_req(1, 2); push_req(2, 3); push_req(12, 19);
    push_req(13, 19); push_req(12, 20); push_req(5, 5);
    drain();

    // extremes: max sizes, oversized registers clamp, placement x 8191 and y -8192
    set_regs(14'd16383, 14'd8192, 14'sh1FFF, 14'sh2000, 14'd8192, 14'd16383,
             14'd8192, 14'd16383);
    push_req(8191, 0); push_req(0, 8191); push_req(8191, 8191);
    push_req(4096, 1); push_req(0, 0);
    drain();

    // zero source / rectangle / canvas sizes each clear the write flag
    set_regs(14'd0, 14'd9, 14'd0, 14'd0, 14'd9, 14'd9, 14'd64, 14'd64);
    push_req(1, 1);
    drain();
    write_reg(nnsa_pkg::RegSrcW, 14'd9); write_reg(nnsa_pkg::RegRectH, 14'd0);
    push_req(1, 1);
    drain();
    write_reg(nnsa_pkg::RegRectH, 14'd9); write_reg(nnsa_pkg::RegCanvW, 14'd0);
    push_req(1, 1);
    drain();

    // downscale with large offsets, long receiver stall
    set_regs(14'd8000, 14'd6000, 14'd100, 14'd200, 14'd300, 14'd700, 14'd8192,
             14'd8192);
    rx_hold = 1'b1;
    random_phase(60);
    repeat (150) @(posedge clk_i);
    rx_hold = 1'b0;
    drain();

    // random settings
    repeat (8) begin
      set_regs(rnd_size(), rnd_size(), 14'($urandom_range(0, 16383)),
               14'($urandom_range(0, 16383)), rnd_size(), rnd_size(), rnd_size(),
               rnd_size());
      random_phase(40);
      // sender waits for the pipe to empty midway
      while (pending_reqs.size() > 20) @(posedge clk_i);
      tx_pause = 1'b1;
      while (expected_addrs.size() != 0 || s_axis_tvalid) @(posedge clk_i);
      tx_pause = 1'b0;
      random_phase(40);
      drain();
    end

    // small placements near the canvas edges
    set_regs(14'd3, 14'd4, 14'd60, 14'd30, 14'd10, 14'd10, 14'd64, 14'd32);
    random_phase(60);
    drain();

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/nnsa_pkg.sv
hdl/nearest_neighbor_scale_address_unit.sv
tb/nearest_neighbor_scale_address_unit_tb.sv
